@@ src/pvfd_pkg.sv @@
// Package for the particle void-fraction deposit block: sizes, codes and shared types.
// Used by pvfd_cell_ram, pvfd_arith and particle_void_fraction_deposit_core.
// No dependencies.
package pvfd_pkg;

  // Mesh size and field widths.
  localparam int NUM_CELLS = 4096;
  localparam int CELL_AW   = $clog2(NUM_CELLS);
  localparam int IDX_W     = 13;
  localparam int RAD_W     = 16;
  localparam int CV_W      = 48;
  localparam int VOL_W     = 54;
  localparam int FRAC_W    = 17;
  localparam int CELL_W    = 16;
  localparam int CFG_W     = 16;
  localparam int DROP_W    = 17;
  localparam int MUL_W     = 32;

  // Sphere factor 4/3*pi in Q3.16.
  localparam logic [MUL_W-1:0] SPHERE_K = 32'd274517;

  // Register reset values.
  localparam logic [CFG_W-1:0] RESET_ALPHA_MIN = 16'd0;
  localparam logic [CFG_W-1:0] RESET_FRACTION  = 16'd32768;
  localparam logic [CFG_W-1:0] RESET_SCALE     = 16'd4096;

  // Sequencer step counts.
  localparam int MUL_STEPS = 10;
  localparam int DIV_STEPS = DROP_W;
  localparam int STEP_W    = 5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ALPHA_MIN = 2'd0;
  localparam logic [1:0] CFG_INIT_FRAC = 2'd1;
  localparam logic [1:0] CFG_VOL_SCALE = 2'd2;

  typedef enum logic [1:0] {
    OP_DEPOSIT = 2'd0,
    OP_READ    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_RD,
    ST_MUL,
    ST_DIV,
    ST_WB,
    ST_FIN
  } state_t;

  // Commands for the shared multiply/divide unit.
  typedef enum logic [3:0] {
    AC_IDLE,
    AC_SQ,
    AC_CUBE,
    AC_SC_LO,
    AC_SC_HI,
    AC_SUM_A,
    AC_K_LO,
    AC_K_HI,
    AC_RND,
    AC_VOL,
    AC_DIV_INIT,
    AC_DIV_STEP
  } arith_cmd_t;

  // Access request to the cell fraction memory.
  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] waddr;
    logic [CELL_W-1:0]  wdata;
    logic               re;
    logic [CELL_AW-1:0] raddr;
  } ram_req_t;

endpackage

@@ src/pvfd_cell_ram.sv @@
// Cell void-fraction memory: one write port and one read port with registered read data.
// Depends on pvfd_pkg for sizes and the request struct.
module pvfd_cell_ram (
  input  logic                             clk,
  input  pvfd_pkg::ram_req_t               req,
  output logic [pvfd_pkg::CELL_W-1:0]      rdata
);

  logic [pvfd_pkg::CELL_W-1:0] mem [pvfd_pkg::NUM_CELLS];
  logic [pvfd_pkg::CELL_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/pvfd_arith.sv @@
// Shared arithmetic unit: one registered 32x32 multiplier with an accumulator for the
// particle volume, and a restoring divider step for the fraction drop. Depends on pvfd_pkg.
module pvfd_arith (
  input  logic                             clk,
  input  pvfd_pkg::arith_cmd_t             cmd,
  input  logic [pvfd_pkg::RAD_W-1:0]       radius,
  input  logic [pvfd_pkg::CFG_W-1:0]       scale,
  input  logic [pvfd_pkg::CV_W-1:0]        cv,
  output logic [pvfd_pkg::VOL_W-1:0]       vol,
  output logic [pvfd_pkg::DROP_W-1:0]      drop
);

  logic [2*pvfd_pkg::MUL_W-1:0] prod_r;
  logic [pvfd_pkg::CFG_W-1:0]   hi_r;
  logic [2*pvfd_pkg::MUL_W-1:0] acc_r;
  logic [pvfd_pkg::VOL_W-1:0]   vol_r;
  logic                         sat_r;
  logic [pvfd_pkg::CV_W-1:0]    rem_r;
  logic [pvfd_pkg::DROP_W-1:0]  num_r;
  logic [pvfd_pkg::DROP_W-1:0]  quo_r;

  logic [pvfd_pkg::MUL_W-1:0]   mul_a;
  logic [pvfd_pkg::MUL_W-1:0]   mul_b;
  logic                         mul_en;
  logic [2*pvfd_pkg::MUL_W-1:0] mul_res;
  logic [pvfd_pkg::VOL_W+1:0]   vol_sum;
  logic [pvfd_pkg::CV_W:0]      div_t;
  logic [pvfd_pkg::CV_W+1:0]    div_diff;
  logic                         div_ge;

  // Multiplier operand selection per command.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd)
      pvfd_pkg::AC_SQ: begin
        mul_a = {16'd0, radius};
        mul_b = {16'd0, radius};
      end
      pvfd_pkg::AC_CUBE: begin
        mul_a = prod_r[pvfd_pkg::MUL_W-1:0];
        mul_b = {16'd0, radius};
      end
      pvfd_pkg::AC_SC_LO: begin
        mul_a = prod_r[pvfd_pkg::MUL_W-1:0];
        mul_b = {16'd0, scale};
      end
      pvfd_pkg::AC_SC_HI: begin
        mul_a = {16'd0, hi_r};
        mul_b = {16'd0, scale};
      end
      pvfd_pkg::AC_K_LO: begin
        mul_a = acc_r[pvfd_pkg::MUL_W-1:0];
        mul_b = pvfd_pkg::SPHERE_K;
      end
      pvfd_pkg::AC_K_HI: begin
        mul_a = acc_r[2*pvfd_pkg::MUL_W-1:pvfd_pkg::MUL_W];
        mul_b = pvfd_pkg::SPHERE_K;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  // Volume assembly: high partial product shifted by 4 plus the rounded low part.
  assign vol_sum = {1'b0, prod_r[50:0], 4'd0} + {33'd0, acc_r[22:0]};

  // One restoring division step: bring down the next numerator bit and try a subtract.
  assign div_t    = {rem_r, num_r[pvfd_pkg::DROP_W-1]};
  assign div_diff = {1'b0, div_t} - {2'b00, cv};
  assign div_ge   = ~div_diff[pvfd_pkg::CV_W+1];

  // Multiplier result register.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_res;
    end
  end

  // Accumulator and volume registers.
  always_ff @(posedge clk) begin
    case (cmd)
      pvfd_pkg::AC_SC_LO: begin
        hi_r <= prod_r[47:32];
      end
      pvfd_pkg::AC_SC_HI: begin
        acc_r <= prod_r;
      end
      pvfd_pkg::AC_SUM_A: begin
        acc_r <= acc_r + {prod_r[pvfd_pkg::MUL_W-1:0], 32'd0};
      end
      pvfd_pkg::AC_K_HI: begin
        acc_r <= prod_r;
      end
      pvfd_pkg::AC_RND: begin
        acc_r <= (acc_r + 64'd134217728) >> 28;
      end
      pvfd_pkg::AC_VOL: begin
        if (vol_sum[pvfd_pkg::VOL_W+1:pvfd_pkg::VOL_W] != 2'b00) begin
          vol_r <= '1;
        end else begin
          vol_r <= vol_sum[pvfd_pkg::VOL_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Divider registers. A volume of at least four cell volumes saturates the drop.
  always_ff @(posedge clk) begin
    case (cmd)
      pvfd_pkg::AC_DIV_INIT: begin
        sat_r <= (vol_r >= {4'd0, cv, 2'b00});
        rem_r <= vol_r[pvfd_pkg::CV_W+1:2];
        num_r <= {vol_r[1:0], 15'd0};
        quo_r <= '0;
      end
      pvfd_pkg::AC_DIV_STEP: begin
        rem_r <= div_ge ? div_diff[pvfd_pkg::CV_W-1:0] : div_t[pvfd_pkg::CV_W-1:0];
        num_r <= {num_r[pvfd_pkg::DROP_W-2:0], 1'b0};
        quo_r <= {quo_r[pvfd_pkg::DROP_W-2:0], div_ge};
      end
      default: begin
      end
    endcase
  end

  assign vol  = vol_r;
  assign drop = sat_r ? '1 : quo_r;

endmodule

@@ src/particle_void_fraction_deposit_core.sv @@
// Top level of the particle void-fraction deposit block: sequencer, registers, output stage.
// Depends on pvfd_pkg, pvfd_cell_ram and pvfd_arith.
//
// Usage:
//   Input channel (in_valid/in_stall) carries op, cell_index, radius and cell_volume.
//   Result channel (out_valid/out_stall) returns fraction, particle_volume, in_domain and
//   limited; every input transfer yields exactly one result transfer.
//   Configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) writes alpha_min (0),
//   initial_fraction (1) and volume_scale (2); cfg_ready is always high.
//   One item is in work at a time; in_stall is high while it is processed.
//   Deposit with a valid cell: the item runs ten multiply and assembly steps on the
//   shared unit, seventeen restoring divider steps and a write-back, then the output
//   load, which waits while an earlier result is held by out_stall; the next item can
//   be taken once the output register is loaded.
//   Read with a valid cell: a memory read, then the output load. Out-of-range or no-op:
//   straight to the output load. Clear: one memory write per cycle, then the output load.
//   After reset the block sweeps all NUM_CELLS cells to 32768, one per cycle, with in_stall
//   high; configuration writes are taken during that sweep.
//   A finished result sits in the output register while out_stall is high, and the next
//   item may already be taken and worked on; it waits only to hand over its own result.
module particle_void_fraction_deposit_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_op,
  input  logic signed [pvfd_pkg::IDX_W-1:0]   in_cell_index,
  input  logic [pvfd_pkg::RAD_W-1:0]          in_radius,
  input  logic [pvfd_pkg::CV_W-1:0]           in_cell_volume,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pvfd_pkg::FRAC_W-1:0]  out_fraction,
  output logic [pvfd_pkg::VOL_W-1:0]          out_particle_volume,
  output logic                                out_in_domain,
  output logic                                out_limited,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [pvfd_pkg::CFG_W-1:0]          cfg_data
);

  pvfd_pkg::state_t                  state_r;
  pvfd_pkg::state_t                  state_nxt;
  logic [pvfd_pkg::STEP_W-1:0]       step_r;
  logic [pvfd_pkg::STEP_W-1:0]       step_nxt;
  logic [pvfd_pkg::CELL_AW-1:0]      clr_cnt_r;
  logic [pvfd_pkg::CELL_AW-1:0]      clr_cnt_nxt;

  pvfd_pkg::op_t                     op_r;
  logic                              ok_r;
  logic [pvfd_pkg::CELL_AW-1:0]      addr_r;
  logic [pvfd_pkg::RAD_W-1:0]        radius_r;
  logic [pvfd_pkg::CV_W-1:0]         cv_r;
  logic [pvfd_pkg::CELL_W-1:0]       cell_r;
  logic                              limit_r;

  logic [pvfd_pkg::CFG_W-1:0]        alpha_min_r;
  logic [pvfd_pkg::CFG_W-1:0]        init_frac_r;
  logic [pvfd_pkg::CFG_W-1:0]        vol_scale_r;

  logic                              out_valid_r;
  logic [pvfd_pkg::FRAC_W-1:0]       out_fraction_r;
  logic [pvfd_pkg::VOL_W-1:0]        out_volume_r;
  logic                              out_domain_r;
  logic                              out_limited_r;

  pvfd_pkg::op_t                     in_op_t;
  logic                              in_xfer;
  logic                              in_ok;
  logic                              sweep_last;
  logic                              fin_load;
  pvfd_pkg::ram_req_t                ram_req;
  logic [pvfd_pkg::CELL_W-1:0]       ram_rdata;
  pvfd_pkg::arith_cmd_t              arith_cmd;
  logic [pvfd_pkg::VOL_W-1:0]        arith_vol;
  logic [pvfd_pkg::DROP_W-1:0]       arith_drop;
  logic [pvfd_pkg::CELL_W+1:0]       wb_diff;
  logic                              wb_clamp;
  logic [pvfd_pkg::CELL_W-1:0]       wb_cell;
  logic [pvfd_pkg::FRAC_W-1:0]       fin_fraction;
  logic [pvfd_pkg::VOL_W-1:0]        fin_volume;
  logic                              fin_domain;

  // Cell memory and shared arithmetic unit.
  pvfd_cell_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  pvfd_arith u_arith (
    .clk    (clk),
    .cmd    (arith_cmd),
    .radius (radius_r),
    .scale  (vol_scale_r),
    .cv     (cv_r),
    .vol    (arith_vol),
    .drop   (arith_drop)
  );

  // Input decode: a cell index is valid when it is non-negative and below the mesh size.
  assign in_op_t = pvfd_pkg::op_t'(in_op);
  assign in_xfer = in_valid && !in_stall;
  assign in_ok   = (in_cell_index[pvfd_pkg::IDX_W-1] == 1'b0) &&
                   ({1'b0, in_cell_index[pvfd_pkg::IDX_W-2:0]} <
                    pvfd_pkg::IDX_W'(pvfd_pkg::NUM_CELLS));

  assign sweep_last = (clr_cnt_r == pvfd_pkg::CELL_AW'(pvfd_pkg::NUM_CELLS - 1));
  assign fin_load   = (state_r == pvfd_pkg::ST_FIN) && (!out_valid_r || !out_stall);

  // Write-back: subtract the drop and clamp at alpha_min.
  assign wb_diff  = {2'b00, ram_rdata} - {1'b0, arith_drop};
  assign wb_clamp = wb_diff[pvfd_pkg::CELL_W+1] ||
                    (wb_diff[pvfd_pkg::CELL_W:0] < {1'b0, alpha_min_r});
  assign wb_cell  = wb_clamp ? alpha_min_r : wb_diff[pvfd_pkg::CELL_W-1:0];

  // Next-state logic.
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = '0;
    clr_cnt_nxt = '0;
    unique case (state_r)
      pvfd_pkg::ST_INIT: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (sweep_last) begin
          clr_cnt_nxt = '0;
          state_nxt   = pvfd_pkg::ST_IDLE;
        end
      end
      pvfd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_op_t)
            pvfd_pkg::OP_CLEAR:   state_nxt = pvfd_pkg::ST_CLEAR;
            pvfd_pkg::OP_DEPOSIT: state_nxt = in_ok ? pvfd_pkg::ST_MUL : pvfd_pkg::ST_FIN;
            pvfd_pkg::OP_READ:    state_nxt = in_ok ? pvfd_pkg::ST_RD : pvfd_pkg::ST_FIN;
            pvfd_pkg::OP_NOP:     state_nxt = pvfd_pkg::ST_FIN;
            default:              state_nxt = pvfd_pkg::ST_FIN;
          endcase
        end
      end
      pvfd_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (sweep_last) begin
          clr_cnt_nxt = '0;
          state_nxt   = pvfd_pkg::ST_FIN;
        end
      end
      pvfd_pkg::ST_RD: begin
        state_nxt = pvfd_pkg::ST_FIN;
      end
      pvfd_pkg::ST_MUL: begin
        step_nxt = step_r + 1'b1;
        if (step_r == pvfd_pkg::STEP_W'(pvfd_pkg::MUL_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = pvfd_pkg::ST_DIV;
        end
      end
      pvfd_pkg::ST_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == pvfd_pkg::STEP_W'(pvfd_pkg::DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = pvfd_pkg::ST_WB;
        end
      end
      pvfd_pkg::ST_WB: begin
        state_nxt = pvfd_pkg::ST_FIN;
      end
      pvfd_pkg::ST_FIN: begin
        if (fin_load) begin
          state_nxt = pvfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pvfd_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs: memory requests, arithmetic commands and input stall.
  always_comb begin
    ram_req       = '0;
    ram_req.raddr = in_cell_index[pvfd_pkg::CELL_AW-1:0];
    arith_cmd     = pvfd_pkg::AC_IDLE;
    in_stall      = 1'b1;
    unique case (state_r)
      pvfd_pkg::ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt_r;
        ram_req.wdata = pvfd_pkg::RESET_FRACTION;
      end
      pvfd_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        ram_req.re = in_xfer && in_ok &&
                     ((in_op_t == pvfd_pkg::OP_DEPOSIT) || (in_op_t == pvfd_pkg::OP_READ));
      end
      pvfd_pkg::ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt_r;
        ram_req.wdata = init_frac_r;
      end
      pvfd_pkg::ST_MUL: begin
        unique case (step_r)
          5'd0:    arith_cmd = pvfd_pkg::AC_SQ;
          5'd1:    arith_cmd = pvfd_pkg::AC_CUBE;
          5'd2:    arith_cmd = pvfd_pkg::AC_SC_LO;
          5'd3:    arith_cmd = pvfd_pkg::AC_SC_HI;
          5'd4:    arith_cmd = pvfd_pkg::AC_SUM_A;
          5'd5:    arith_cmd = pvfd_pkg::AC_K_LO;
          5'd6:    arith_cmd = pvfd_pkg::AC_K_HI;
          5'd7:    arith_cmd = pvfd_pkg::AC_RND;
          5'd8:    arith_cmd = pvfd_pkg::AC_VOL;
          5'd9:    arith_cmd = pvfd_pkg::AC_DIV_INIT;
          default: arith_cmd = pvfd_pkg::AC_IDLE;
        endcase
      end
      pvfd_pkg::ST_DIV: begin
        arith_cmd = pvfd_pkg::AC_DIV_STEP;
      end
      pvfd_pkg::ST_WB: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = addr_r;
        ram_req.wdata = wb_cell;
      end
      default: begin
      end
    endcase
  end

  // Result fields by operation.
  always_comb begin
    fin_fraction = '0;
    fin_volume   = '0;
    fin_domain   = 1'b0;
    unique case (op_r)
      pvfd_pkg::OP_DEPOSIT: begin
        if (ok_r) begin
          fin_fraction = {1'b0, cell_r};
          fin_volume   = arith_vol;
          fin_domain   = 1'b1;
        end else begin
          fin_fraction = '1;
        end
      end
      pvfd_pkg::OP_READ: begin
        if (ok_r) begin
          fin_fraction = {1'b0, cell_r};
          fin_domain   = 1'b1;
        end else begin
          fin_fraction = '1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pvfd_pkg::ST_INIT;
      step_r      <= '0;
      clr_cnt_r   <= '0;
      limit_r     <= 1'b0;
      out_valid_r <= 1'b0;
      alpha_min_r <= pvfd_pkg::RESET_ALPHA_MIN;
      init_frac_r <= pvfd_pkg::RESET_FRACTION;
      vol_scale_r <= pvfd_pkg::RESET_SCALE;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      clr_cnt_r <= clr_cnt_nxt;

      // Sticky limit flag: dropped by a clear, set by a clamped write-back.
      if (in_xfer && (in_op_t == pvfd_pkg::OP_CLEAR)) begin
        limit_r <= 1'b0;
      end else if ((state_r == pvfd_pkg::ST_WB) && wb_clamp) begin
        limit_r <= 1'b1;
      end

      // Output register valid.
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pvfd_pkg::CFG_ALPHA_MIN: alpha_min_r <= cfg_data;
          pvfd_pkg::CFG_INIT_FRAC: init_frac_r <= cfg_data;
          pvfd_pkg::CFG_VOL_SCALE: vol_scale_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Item payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_op_t;
      ok_r     <= in_ok;
      addr_r   <= in_cell_index[pvfd_pkg::CELL_AW-1:0];
      radius_r <= in_radius;
      cv_r     <= in_cell_volume;
    end
    if (state_r == pvfd_pkg::ST_RD) begin
      cell_r <= ram_rdata;
    end else if (state_r == pvfd_pkg::ST_WB) begin
      cell_r <= wb_cell;
    end
    if (fin_load) begin
      out_fraction_r <= fin_fraction;
      out_volume_r   <= fin_volume;
      out_domain_r   <= fin_domain;
      out_limited_r  <= limit_r;
    end
  end

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_fraction        = $signed(out_fraction_r);
  assign out_particle_volume = out_volume_r;
  assign out_in_domain       = out_domain_r;
  assign out_limited         = out_limited_r;

endmodule

@@ tb/particle_void_fraction_deposit_checker.sv @@
// Checker for the particle void-fraction deposit core: watches the input, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on pvfd_pkg for widths, register indexes and operation codes.
module particle_void_fraction_deposit_checker
  import pvfd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic signed [IDX_W-1:0]  in_cell_index,
  input  logic [RAD_W-1:0]         in_radius,
  input  logic [CV_W-1:0]          in_cell_volume,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [FRAC_W-1:0] out_fraction,
  input  logic [VOL_W-1:0]         out_particle_volume,
  input  logic                     out_in_domain,
  input  logic                     out_limited,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output int                       mismatches,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [127:0] VOLUME_CAP = (128'd1 << VOL_W) - 1;
  localparam logic [127:0] LOSS_CAP   = (128'd1 << DROP_W) - 1;

  typedef struct packed {
    logic signed [FRAC_W-1:0] fraction;
    logic [VOL_W-1:0]         particle_volume;
    logic                     in_domain;
    logic                     limited;
  } cell_result_t;

  // Mirror of the block's registers and cell memory.
  logic [CFG_W-1:0]  alpha_floor;
  logic [CFG_W-1:0]  fill_value;
  logic [CFG_W-1:0]  volume_weight;
  logic [CELL_W-1:0] cell_frac [NUM_CELLS];
  logic              limit_flag;

  cell_result_t expected_outcomes[$];

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Scaled sphere volume, rounded half up and saturated to the result width.
  function automatic logic [VOL_W-1:0] sphere_volume(logic [RAD_W-1:0] rad);
    logic [127:0] p;
    p = 128'(rad) * 128'(rad) * 128'(rad) * 128'(volume_weight) * 128'(SPHERE_K);
    p = (p + (128'd1 << 27)) >> 28;
    if (p > VOLUME_CAP) return '1;
    return p[VOL_W-1:0];
  endfunction

  // Fraction removed from the cell: floor(V * 2^15 / cell volume), saturated.
  function automatic logic [DROP_W-1:0] fraction_loss(logic [VOL_W-1:0] vol,
                                                      logic [CV_W-1:0] cv);
    logic [127:0] q;
    if (cv == '0) return '1;
    q = (128'(vol) << 15) / 128'(cv);
    if (q > LOSS_CAP) return '1;
    return q[DROP_W-1:0];
  endfunction

  // Applies one input item to the mirrored state and returns its result.
  function automatic cell_result_t deposit_outcome(op_t op, logic [IDX_W-1:0] idx,
                                                   logic [RAD_W-1:0] rad,
                                                   logic [CV_W-1:0] cv);
    cell_result_t res;
    logic [CELL_AW-1:0] cell_sel;
    int next;
    res = '0;
    cell_sel = idx[CELL_AW-1:0];
    case (op) inside
      OP_CLEAR: begin
        for (int i = 0; i < NUM_CELLS; i++) cell_frac[i] = fill_value;
        limit_flag = 1'b0;
      end
      OP_DEPOSIT, OP_READ: begin
        // A negative index names no cell.
        if (idx[IDX_W-1]) begin
          res.fraction = '1;
        end else begin
          res.in_domain = 1'b1;
          if (op == OP_DEPOSIT) begin
            res.particle_volume = sphere_volume(rad);
            next = int'(cell_frac[cell_sel]) -
                   int'(fraction_loss(res.particle_volume, cv));
            // Landing exactly on the floor is not a clamp.
            if (next < int'(alpha_floor)) begin
              next = int'(alpha_floor);
              limit_flag = 1'b1;
            end
            cell_frac[cell_sel] = next[CELL_W-1:0];
          end
          res.fraction = {1'b0, cell_frac[cell_sel]};
        end
      end
      default: ;
    endcase
    res.limited = limit_flag;
    return res;
  endfunction

  // Track every transfer on the three channels.
  always @(posedge clk) begin
    cell_result_t want;
    if (!rst_n) begin
      alpha_floor   = RESET_ALPHA_MIN;
      fill_value    = RESET_FRACTION;
      volume_weight = RESET_SCALE;
      limit_flag    = 1'b0;
      for (int i = 0; i < NUM_CELLS; i++) cell_frac[i] = RESET_FRACTION;
      expected_outcomes.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALPHA_MIN: alpha_floor   = cfg_data;
          CFG_INIT_FRAC: fill_value    = cfg_data;
          CFG_VOL_SCALE: volume_weight = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result transfer with nothing expected", 64'(out_fraction), 0);
        end else begin
          want = expected_outcomes.pop_front();
          if (out_fraction !== want.fraction)
            report_mismatch("fraction", 64'(out_fraction), 64'(want.fraction));
          if (out_particle_volume !== want.particle_volume)
            report_mismatch("particle_volume", 64'(out_particle_volume),
                            64'(want.particle_volume));
          if (out_in_domain !== want.in_domain)
            report_mismatch("in_domain", 64'(out_in_domain), 64'(want.in_domain));
          if (out_limited !== want.limited)
            report_mismatch("limited", 64'(out_limited), 64'(want.limited));
        end
      end
      if (in_valid && !in_stall)
        expected_outcomes.push_back(deposit_outcome(op_t'(in_op), in_cell_index,
                                                    in_radius, in_cell_volume));
      outstanding <= expected_outcomes.size();
    end
  end

endmodule

@@ tb/particle_void_fraction_deposit_core_tb.sv @@
// Testbench top for the particle void-fraction deposit core: clock, reset, stimulus
// and verdict. Depends on pvfd_pkg, the core and particle_void_fraction_deposit_checker.
module particle_void_fraction_deposit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pvfd_pkg::*;

  localparam int PHASES        = 5;
  localparam int ITEMS_PER_PHASE = 340;
  localparam int HOLDOFF_CYCLES  = 300;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_op = OP_NOP;
  logic signed [IDX_W-1:0]  in_cell_index = '0;
  logic [RAD_W-1:0]         in_radius = '0;
  logic [CV_W-1:0]          in_cell_volume = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [FRAC_W-1:0] out_fraction;
  logic [VOL_W-1:0]         out_particle_volume;
  logic                     out_in_domain;
  logic                     out_limited;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [1:0]               cfg_index = CFG_ALPHA_MIN;
  logic [CFG_W-1:0]         cfg_data = '0;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;

  particle_void_fraction_deposit_core dut (.*);

  particle_void_fraction_deposit_checker checker_i (.*);

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("particle_void_fraction_deposit_core_tb failed");
    $finish;
  end

  // Result side: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= HOLDOFF_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one item, waits for its transfer, then idles at random.
  task automatic offer_item(op_t op, logic signed [IDX_W-1:0] idx,
                            logic [RAD_W-1:0] rad, logic [CV_W-1:0] cv);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_cell_index  <= idx;
    in_radius      <= rad;
    in_cell_volume <= cv;
    do @(posedge clk); while (in_stall);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Mostly deposits and reads on a few cells so that they run down and clamp.
  task automatic random_item();
    int pick;
    int w;
    op_t op;
    logic signed [IDX_W-1:0] idx;
    logic [RAD_W-1:0] rad;
    logic [63:0] cv_mask;
    logic [CV_W-1:0] cv;
    pick = $urandom_range(99);
    if (pick < 60) op = OP_DEPOSIT;
    else if (pick < 88) op = OP_READ;
    else if (pick < 89) op = OP_CLEAR;
    else op = OP_NOP;
    pick = $urandom_range(99);
    if (pick < 75) idx = IDX_W'($urandom_range(15));
    else if (pick < 85) idx = IDX_W'($urandom_range(NUM_CELLS - 1));
    else if (pick < 95) idx = {1'b1, 12'($urandom)};
    else if (pick < 97) idx = '1;
    else if (pick < 99) idx = IDX_W'(NUM_CELLS - 1);
    else idx = '0;
    w = $urandom_range(RAD_W);
    rad = RAD_W'($urandom & ((32'd1 << w) - 1));
    if ($urandom_range(99) < 3) rad = '1;
    w = $urandom_range(CV_W);
    cv_mask = (64'd1 << w) - 1;
    cv = CV_W'({$urandom, $urandom} & cv_mask);
    if ($urandom_range(99) < 2) cv = '1;
    offer_item(op, idx, rad, cv);
  endtask

  // Writes all three registers back to back.
  task automatic program_regs(logic [CFG_W-1:0] amin, logic [CFG_W-1:0] ifrac,
                              logic [CFG_W-1:0] vscale);
    logic [1:0] reg_idx [3];
    logic [CFG_W-1:0] reg_val [3];
    reg_idx = '{CFG_ALPHA_MIN, CFG_INIT_FRAC, CFG_VOL_SCALE};
    reg_val = '{amin, ifrac, vscale};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_data  <= reg_val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Holds the sender until every expected result has been transferred.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Let the power-up sweep of the cell memory finish.
    repeat (2) @(posedge clk);
    while (in_stall) @(posedge clk);
    program_regs(16'd0, 16'd32768, 16'd4096);

    // Directed items: index extremes, every op, the special cases.
    offer_item(OP_READ, 13'sd0, 16'd0, 48'd0);
    offer_item(OP_READ, 13'sd4095, 16'd0, 48'd0);
    offer_item(OP_READ, -13'sd1, 16'd0, 48'd0);
    offer_item(OP_READ, -13'sd4096, 16'hFFFF, '1);
    // A drop of exactly 32768 lands on the floor of zero, which is no clamp.
    offer_item(OP_DEPOSIT, 13'sd9, 16'd10, 48'd4189);
    offer_item(OP_NOP, 13'sd9, 16'd0, 48'd0);
    offer_item(OP_DEPOSIT, 13'sd0, 16'd0, 48'd1);
    offer_item(OP_DEPOSIT, 13'sd5, 16'd10, 48'd100000);
    offer_item(OP_DEPOSIT, 13'sd7, 16'd100, 48'd0);
    offer_item(OP_DEPOSIT, 13'sd4095, 16'hFFFF, '1);
    offer_item(OP_DEPOSIT, -13'sd1, 16'd50, 48'd1000);
    offer_item(OP_DEPOSIT, -13'sd4096, 16'hFFFF, 48'd0);
    offer_item(OP_DEPOSIT, 13'sd1, 16'hFFFF, 48'd1);
    offer_item(OP_NOP, -13'sd1, 16'hFFFF, '1);
    offer_item(OP_READ, 13'sd7, 16'd0, 48'd0);
    offer_item(OP_CLEAR, 13'sd0, 16'd0, 48'd0);
    offer_item(OP_READ, 13'sd7, 16'd0, 48'd0);
    offer_item(OP_NOP, 13'sd0, 16'd0, 48'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: program_regs(16'd0, 16'd32768, 16'd4096);
        1: program_regs(16'd32768, 16'd0, 16'd0);
        2: program_regs(16'd0, 16'd32768, 16'hFFFF);
        default: program_regs(CFG_W'($urandom_range(16384)),
                              CFG_W'($urandom_range(32768, 16384)),
                              CFG_W'($urandom_range(65535)));
      endcase
      // Idle pattern: none, sender, receiver, both lightly.
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 79; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 79; end
        default: begin send_idle_pct = 13; stall_pct <= 13; end
      endcase
      offer_item(OP_CLEAR, 13'sd0, 16'd0, 48'd0);
      offer_item(OP_DEPOSIT, 13'sd0, 16'hFFFF, '1);
      // Back up the result side while items keep coming in.
      if (phase == 0) hold_req <= hold_req + 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("particle_void_fraction_deposit_core_tb passed");
    else
      $display("particle_void_fraction_deposit_core_tb failed");
    $finish;
  end

endmodule

@@ particle_void_fraction_deposit_core.f @@
src/pvfd_pkg.sv
src/pvfd_cell_ram.sv
src/pvfd_arith.sv
src/particle_void_fraction_deposit_core.sv
tb/particle_void_fraction_deposit_checker.sv
tb/particle_void_fraction_deposit_core_tb.sv
